### src/aip_pkg.sv
package aip_pkg;

    localparam int COUNT_BITS = 16;

    localparam int VALUE_BITS = 64;
    localparam int CHARS_BITS = 16;
    localparam int BASE_BITS  = 5;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_MODE    = 2'd0;
    localparam logic [1:0] CFG_RESULT_SIZE  = 2'd1;
    localparam logic [1:0] CFG_MAX_DIGITS   = 2'd2;
    localparam logic [1:0] CFG_STORE_ENABLE = 2'd3;

    // base_mode codes
    localparam logic [2:0] MODE_AUTO = 3'd0;
    localparam logic [2:0] MODE_BIN  = 3'd1;
    localparam logic [2:0] MODE_OCT  = 3'd2;
    localparam logic [2:0] MODE_DEC  = 3'd3;
    localparam logic [2:0] MODE_HEX  = 3'd4;

    // result_size codes
    localparam logic [1:0] SIZE_16 = 2'd0;
    localparam logic [1:0] SIZE_32 = 2'd1;
    localparam logic [1:0] SIZE_64 = 2'd2;

    localparam logic [BASE_BITS-1:0] BASE_2  = 5'd2;
    localparam logic [BASE_BITS-1:0] BASE_8  = 5'd8;
    localparam logic [BASE_BITS-1:0] BASE_10 = 5'd10;
    localparam logic [BASE_BITS-1:0] BASE_16 = 5'd16;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  matched;
        logic [CHARS_BITS-1:0] chars_read;
        logic                  terminator_kept;
    } out_item_t;

endpackage

### src/ascii_integer_parser.sv
// ASCII integer parser, one character per item.
//
// Input channel in_item carries in_char and end_of_input under in_valid /
// in_stall; the result channel out_item carries value, matched, chars_read
// and terminator_kept under out_valid / out_stall. An item is taken when
// valid is high and stall is low. An item whose character ends a number
// yields one result; other items update the parse and yield nothing. When
// terminator_kept is set, present that character again to start the next
// parse.
//
// An accepted item lands in an input register and is parsed from there into
// the result register once that register is free to take it. One item per
// cycle is sustained while the result side does not stall; the rate is set
// by the combinational shift-add accumulate of the parse stage.
//
// The configuration port (cfg_write, cfg_index, cfg_data) writes a register;
// write it only while no parse is in progress.
// Reset empties both registers, returns the parse to whitespace skipping
// and loads the register defaults. A stalled result holds the result
// register; the input register then holds its item and in_stall rises.
module ascii_integer_parser
    import aip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item,
    input  logic      cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_AFTER_ZERO,
        PH_FIRST_DIGIT,
        PH_DIGITS
    } phase_t;

    logic [2:0] base_mode_reg;
    logic [1:0] result_size_reg;
    logic [7:0] max_digits_reg;
    logic       store_enable_reg;

    phase_t                  phase_reg, phase_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [BASE_BITS-1:0]    base_reg, base_next;
    logic [7:0]              digits_left_reg, digits_left_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;

    logic out_free;
    logic fire;
    logic emit;

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd31;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = 5'(c - CH_ZERO);
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            d = 5'(c - CH_UPPER_A) + 5'd10;
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            d = 5'(c - CH_LOWER_A) + 5'd10;
        end
        return d;
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Parse stage
    always_comb
    begin
        logic [7:0]            c;
        logic                  ended;
        logic                  recognized;
        logic                  kept;
        logic                  consumed;
        logic                  run_digit;
        logic                  stage_digits;
        logic [VALUE_BITS-1:0] acc_in;
        logic                  neg_in;
        logic [BASE_BITS-1:0]  base_in;
        logic [7:0]            dl_in;
        logic [4:0]            d;
        logic [VALUE_BITS-1:0] scaled;
        logic [VALUE_BITS-1:0] dterm;
        logic [VALUE_BITS-1:0] masked;
        logic [COUNT_BITS-1:0] count_now;

        c     = in_item_reg.in_char;
        ended = in_item_reg.end_of_input || (c == CH_NUL);

        phase_next       = phase_reg;
        acc_next         = acc_reg;
        neg_next         = neg_reg;
        base_next        = base_reg;
        digits_left_next = digits_left_reg;
        emit             = 1'b0;
        recognized       = 1'b0;
        kept             = 1'b0;
        consumed         = 1'b0;
        run_digit        = 1'b0;
        stage_digits     = 1'b0;
        acc_in           = acc_reg;
        neg_in           = neg_reg;
        base_in          = base_reg;
        dl_in            = digits_left_reg;
        scaled           = '0;
        dterm            = '0;

        case (phase_reg)
            PH_SKIP:
            begin
                if (ended)
                begin
                    emit = 1'b1;
                end
                else if (c inside {[CH_TAB:CH_CR], CH_SPACE})
                begin
                    consumed = 1'b1;
                end
                else
                begin
                    acc_in = '0;
                    neg_in = 1'b0;
                    dl_in  = max_digits_reg;
                    digits_left_next = max_digits_reg;
                    acc_next = '0;
                    neg_next = 1'b0;
                    case (base_mode_reg)
                        MODE_BIN: base_in = BASE_2;
                        MODE_OCT: base_in = BASE_8;
                        MODE_HEX: base_in = BASE_16;
                        default:  base_in = BASE_10;
                    endcase
                    base_next  = base_in;
                    phase_next = PH_FIRST_DIGIT;
                    if (base_mode_reg == MODE_AUTO && c == CH_PERCENT)
                    begin
                        base_next = BASE_2;
                        consumed  = 1'b1;
                    end
                    else if (base_mode_reg == MODE_AUTO && c == CH_ZERO)
                    begin
                        base_next  = BASE_8;
                        consumed   = 1'b1;
                        phase_next = PH_AFTER_ZERO;
                    end
                    else if (base_in == BASE_10 && (c == CH_MINUS || c == CH_PLUS))
                    begin
                        neg_next = (c == CH_MINUS);
                        consumed = 1'b1;
                    end
                    else
                    begin
                        run_digit = 1'b1;
                    end
                end
            end
            PH_AFTER_ZERO:
            begin
                if (ended)
                begin
                    emit       = 1'b1;
                    recognized = 1'b1;
                end
                else if (c == CH_LOWER_X || c == CH_UPPER_X)
                begin
                    base_next  = BASE_16;
                    consumed   = 1'b1;
                    phase_next = PH_FIRST_DIGIT;
                end
                else
                begin
                    base_in      = BASE_8;
                    base_next    = BASE_8;
                    phase_next   = PH_DIGITS;
                    stage_digits = 1'b1;
                    run_digit    = 1'b1;
                end
            end
            default:
            begin
                stage_digits = (phase_reg == PH_DIGITS);
                if (ended)
                begin
                    emit       = 1'b1;
                    recognized = stage_digits;
                end
                else
                begin
                    run_digit = 1'b1;
                end
            end
        endcase

        // The accumulator holds the signed value, so a minus sign subtracts digits
        d = digit_value(c);
        case (base_in)
            BASE_2:  scaled = acc_in << 1;
            BASE_8:  scaled = acc_in << 3;
            BASE_16: scaled = acc_in << 4;
            default: scaled = (acc_in << 3) + (acc_in << 1);
        endcase
        dterm = neg_in ? ('0 - VALUE_BITS'(d)) : VALUE_BITS'(d);

        if (run_digit)
        begin
            if (d >= base_in)
            begin
                emit       = 1'b1;
                recognized = stage_digits;
                kept       = 1'b1;
            end
            else
            begin
                acc_next   = scaled + dterm;
                consumed   = 1'b1;
                phase_next = PH_DIGITS;
                if (dl_in != 8'd0)
                begin
                    digits_left_next = dl_in - 8'd1;
                    if (dl_in == 8'd1)
                    begin
                        emit       = 1'b1;
                        recognized = 1'b1;
                    end
                end
            end
        end

        count_now = count_reg;
        if (consumed && count_reg != '1)
        begin
            count_now = count_reg + COUNT_BITS'(1);
        end
        count_next = count_now;

        case (result_size_reg)
            SIZE_16: masked = {48'd0, acc_next[15:0]};
            SIZE_32: masked = {32'd0, acc_next[31:0]};
            default: masked = acc_next;
        endcase

        result.matched         = recognized && store_enable_reg;
        result.value           = result.matched ? masked : '0;
        result.chars_read      = (32'(count_now) > 32'hFFFF) ? 16'hFFFF : 16'(count_now);
        result.terminator_kept = kept;

        if (emit)
        begin
            phase_next       = PH_SKIP;
            acc_next         = '0;
            neg_next         = 1'b0;
            base_next        = BASE_10;
            digits_left_next = max_digits_reg;
            count_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg    <= MODE_DEC;
            result_size_reg  <= SIZE_32;
            max_digits_reg   <= 8'd0;
            store_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE_MODE:    base_mode_reg    <= cfg_data[2:0];
                CFG_RESULT_SIZE:  result_size_reg  <= cfg_data[1:0];
                CFG_MAX_DIGITS:   max_digits_reg   <= cfg_data;
                CFG_STORE_ENABLE: store_enable_reg <= cfg_data[0];
                default:          base_mode_reg    <= base_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SKIP;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            base_reg        <= BASE_10;
            digits_left_reg <= 8'd0;
            count_reg       <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg       <= phase_next;
                acc_reg         <= acc_next;
                neg_reg         <= neg_next;
                base_reg        <= base_next;
                digits_left_reg <= digits_left_next;
                count_reg       <= count_next;
            end
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
        if (fire && emit)
        begin
            out_item_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_emit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> phase_reg == PH_SKIP && count_reg == '0 && acc_reg == '0)
        else $error("parse state not cleared after a result");

    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.matched |-> out_item_reg.value == '0)
        else $error("unmatched result carries a nonzero value");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

    a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("pending result dropped");
`endif

endmodule

### dv/ascii_integer_parser_checker.sv
`timescale 1ns / 1ps

module ascii_integer_parser_checker
    import aip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_item_t   in_item,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_item_t  out_item,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         results_pending
);

    typedef enum logic [1:0] {SKIP_WS, AFTER_ZERO, FIRST_DIGIT, IN_DIGITS} parse_phase_t;

    // shadow of the configuration registers
    logic [2:0] mode_reg;
    logic [1:0] size_reg;
    logic [7:0] limit_reg;
    logic       store_reg;

    // parse state
    parse_phase_t          phase;
    logic [VALUE_BITS-1:0] acc;
    logic                  neg;
    logic [BASE_BITS-1:0]  radix;
    logic [7:0]            digits_left;
    logic [CHARS_BITS-1:0] consumed;

    out_item_t results_due[$];
    int        fail_count;

    function automatic void restart();
        phase       = SKIP_WS;
        acc         = '0;
        neg         = 1'b0;
        radix       = BASE_10;
        digits_left = limit_reg;
        consumed    = '0;
    endfunction

    function automatic void count_char();
        if (consumed != '1)
            consumed++;
    endfunction

    function automatic out_item_t close_number(input logic recognized, input logic kept);
        out_item_t             r;
        logic [VALUE_BITS-1:0] v;
        r = '0;
        if (recognized && store_reg)
        begin
            v = neg ? -acc : acc;
            if (size_reg == SIZE_16)
                v = {48'b0, v[15:0]};
            else if (size_reg == SIZE_32)
                v = {32'b0, v[31:0]};
            r.value   = v;
            r.matched = 1'b1;
        end
        r.chars_read      = consumed;
        r.terminator_kept = kept;
        restart();
        return r;
    endfunction

    // 31 is above every base, so it marks a non-digit
    function automatic logic [BASE_BITS-1:0] char_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return BASE_BITS'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            return BASE_BITS'(c - CH_UPPER_A + 8'd10);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            return BASE_BITS'(c - CH_LOWER_A + 8'd10);
        return '1;
    endfunction

    function automatic logic add_digit(input logic [7:0] c, output out_item_t r);
        logic [BASE_BITS-1:0] d;
        d = char_digit(c);
        r = '0;
        if (d >= radix)
        begin
            r = close_number(phase == IN_DIGITS, 1'b1);
            return 1'b1;
        end
        acc = acc * VALUE_BITS'(radix) + VALUE_BITS'(d);
        count_char();
        phase = IN_DIGITS;
        if (digits_left != 0)
        begin
            digits_left--;
            if (digits_left == 0)
            begin
                r = close_number(1'b1, 1'b0);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic predict_char(input in_item_t it, output out_item_t r);
        logic [7:0] c;
        logic       ended;
        c     = it.in_char;
        ended = it.end_of_input || c == CH_NUL;
        r     = '0;
        case (phase)
            SKIP_WS:
            begin
                if (ended)
                begin
                    r = close_number(1'b0, 1'b0);
                    return 1'b1;
                end
                if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)
                begin
                    count_char();
                    return 1'b0;
                end
                // latch the digit limit and pick the base on the first real character
                digits_left = limit_reg;
                neg         = 1'b0;
                acc         = '0;
                radix       = BASE_10;
                case (mode_reg)
                    MODE_AUTO:
                    begin
                        if (c == CH_PERCENT)
                        begin
                            radix = BASE_2;
                            count_char();
                            phase = FIRST_DIGIT;
                            return 1'b0;
                        end
                        if (c == CH_ZERO)
                        begin
                            radix = BASE_8;
                            count_char();
                            phase = AFTER_ZERO;
                            return 1'b0;
                        end
                    end
                    MODE_BIN: radix = BASE_2;
                    MODE_OCT: radix = BASE_8;
                    MODE_HEX: radix = BASE_16;
                    default: ;
                endcase
                phase = FIRST_DIGIT;
                if (radix == BASE_10 && (c == CH_MINUS || c == CH_PLUS))
                begin
                    neg = (c == CH_MINUS);
                    count_char();
                    return 1'b0;
                end
                return add_digit(c, r);
            end
            AFTER_ZERO:
            begin
                // a lone zero is already a number
                if (ended)
                begin
                    r = close_number(1'b1, 1'b0);
                    return 1'b1;
                end
                if (c == CH_LOWER_X || c == CH_UPPER_X)
                begin
                    radix = BASE_16;
                    count_char();
                    phase = FIRST_DIGIT;
                    return 1'b0;
                end
                radix = BASE_8;
                phase = IN_DIGITS;
                return add_digit(c, r);
            end
            default:
            begin
                if (ended)
                begin
                    r = close_number(phase == IN_DIGITS, 1'b0);
                    return 1'b1;
                end
                return add_digit(c, r);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            mode_reg   = MODE_DEC;
            size_reg   = SIZE_32;
            limit_reg  = 8'd0;
            store_reg  = 1'b1;
            restart();
            results_due.delete();
            fail_count = 0;
            mismatches      <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_BASE_MODE:    mode_reg  = cfg_data[2:0];
                    CFG_RESULT_SIZE:  size_reg  = cfg_data[1:0];
                    CFG_MAX_DIGITS:   limit_reg = cfg_data;
                    CFG_STORE_ENABLE: store_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with no item waiting: value %h matched %b chars_read %0d",
                           out_item.value, out_item.matched, out_item.chars_read);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (out_item.value !== want.value)
                    begin
                        $error("value: expected %h, got %h", want.value, out_item.value);
                        fail_count++;
                    end
                    if (out_item.matched !== want.matched)
                    begin
                        $error("matched: expected %b, got %b", want.matched, out_item.matched);
                        fail_count++;
                    end
                    if (out_item.chars_read !== want.chars_read)
                    begin
                        $error("chars_read: expected %0d, got %0d",
                               want.chars_read, out_item.chars_read);
                        fail_count++;
                    end
                    if (out_item.terminator_kept !== want.terminator_kept)
                    begin
                        $error("terminator_kept: expected %b, got %b",
                               want.terminator_kept, out_item.terminator_kept);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (predict_char(in_item, want))
                    results_due.push_back(want);
            end
            mismatches      <= fail_count;
            results_pending <= results_due.size();
        end
    end

endmodule

### dv/tb_ascii_integer_parser.sv
`timescale 1ns / 1ps

module tb_ascii_integer_parser;
    import aip_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam logic [1:0] SIZE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASES       = 10;
    localparam int PHASE_CHARS  = 70;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_item   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_item;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = CFG_BASE_MODE;
    logic [7:0] cfg_data  = 8'd0;

    int mismatches;
    int results_pending;

    int burst_left     = 0;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;
    int chars_sent     = 0;

    ascii_integer_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ascii_integer_parser_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_item        (out_item),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_char(input logic [7:0] c, input logic ended);
        int       gap;
        in_item_t it;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        it.in_char      = c;
        it.end_of_input = ended;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    // in_char is a don't-care here, so randomize it
    task automatic send_end();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // wait out every expected result, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input logic [2:0] mode, input logic [1:0] size,
                               input logic [7:0] limit, input logic store);
        logic [7:0] vals [4];
        logic [1:0] regs [4];
        vals[0] = 8'(mode);
        vals[1] = 8'(size);
        vals[2] = limit;
        vals[3] = 8'(store);
        regs[0] = CFG_BASE_MODE;
        regs[1] = CFG_RESULT_SIZE;
        regs[2] = CFG_MAX_DIGITS;
        regs[3] = CFG_STORE_ENABLE;
        settle();
        cfg_write <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] ws_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
    endfunction

    function automatic logic [7:0] digit_char(input int radix);
        int d;
        d = $urandom_range(0, radix - 1);
        if (d < 10)
            return 8'(CH_ZERO + d);
        return 8'(($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + d - 10);
    endfunction

    // whitespace, prefix or sign, digits, then some terminator
    task automatic send_number(input logic [2:0] mode);
        int radix;
        int ndig;
        int pick;
        repeat ($urandom_range(0, 2)) send_char(ws_char(), 1'b0);
        radix = (mode == MODE_BIN) ? 2 : (mode == MODE_OCT) ? 8 : (mode == MODE_HEX) ? 16 : 10;
        if (mode == MODE_AUTO)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0:
                begin
                    send_char(CH_PERCENT, 1'b0);
                    radix = 2;
                end
                1:
                begin
                    send_char(CH_ZERO, 1'b0);
                    send_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X, 1'b0);
                    radix = 16;
                end
                2:
                begin
                    send_char(CH_ZERO, 1'b0);
                    radix = 8;
                end
                default: ;
            endcase
        end
        if (radix == 10 && $urandom_range(0, 2) == 0)
            send_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        repeat (ndig) send_char(digit_char(radix), 1'b0);
        pick = $urandom_range(0, 5);
        if (pick == 0)
            send_char(CH_NUL, 1'b0);
        else if (pick <= 2)
            send_end();
        else
            send_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // result side: random stall patterns, plus one long hold on request
    initial
    begin : result_sink
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            while (span > 0 && !(long_hold_req && !long_hold_done))
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
                span--;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int       start;
        logic [7:0] limit;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: decimal, 32-bit, unlimited, store on
        send_text("\t-9");
        send_char(8'hFF, 1'b0);
        send_text("+z");
        send_end();
        send_text("7");
        send_char(CH_NUL, 1'b0);

        load_config(MODE_AUTO, SIZE_64, 8'd0, 1'b1);
        send_text("0x");
        send_end();
        send_text("0");
        send_end();
        send_text("0Xf");
        send_end();

        // unused mode code parses decimal; digit limit closes on the second digit
        load_config(MODE_UNUSED, SIZE_16, 8'd2, 1'b0);
        send_text("123");
        send_end();

        load_config(MODE_DEC, SIZE_UNUSED, 8'd0, 1'b1);
        send_text("-1");
        send_end();

        load_config(MODE_HEX, SIZE_16, 8'd255, 1'b1);
        send_text("aF");
        send_end();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: limit = 8'd0;
                1: limit = 8'd255;
                2: limit = 8'd1;
                default: limit = 8'($urandom_range(2, 12));
            endcase
            load_config(3'(p % 8), 2'(p % 4), limit, (p % 5) != 3);
            if (p == 2)
                long_hold_req = 1'b1;
            start = chars_sent;
            while (chars_sent - start < PHASE_CHARS)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                else
                    send_number(3'(p % 8));
            end
            // close any open parse before the next register write
            send_end();
        end

        settle();
        if (mismatches == 0 && results_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
src/aip_pkg.sv
src/ascii_integer_parser.sv
dv/ascii_integer_parser_checker.sv
dv/tb_ascii_integer_parser.sv
